@@ hw/rtl/media_packet_to_flv_tag_framer_assert.svh @@
// Assertion macros shared by the framer's checker.
`ifndef MEDIA_PACKET_TO_FLV_TAG_FRAMER_ASSERT_SVH
`define MEDIA_PACKET_TO_FLV_TAG_FRAMER_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define MPFV_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("framer assertion failed");

// A stalled request keeps its valid and the watched signal in the next cycle.
`define MPFV_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) \
        ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
        else $error("framer stall hold violated");

`endif

@@ hw/rtl/mpfv_pkg.sv @@
// ----------------------------------------------------------------------------
// mpfv_pkg
// Types and constants of the media packet to FLV tag framer.
// ----------------------------------------------------------------------------
package mpfv_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    localparam logic [7:0] TYPE_AUDIO     = 8'h08;
    localparam logic [7:0] TYPE_VIDEO     = 8'h09;
    localparam logic [7:0] TYPE_METADATA  = 8'h12;
    localparam logic [7:0] TYPE_AGGREGATE = 8'h16;

    localparam logic [1:0] KIND_TAG  = 2'd0;
    localparam logic [1:0] KIND_PASS = 2'd1;
    localparam logic [1:0] KIND_AGG  = 2'd2;
    localparam logic [1:0] KIND_DROP = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SMALL   = 2'd1;
    localparam logic [1:0] ST_CORRUPT = 2'd2;

    localparam int TAG_HDR_LEN = 11;
    localparam int MAX_RESULTS = 15;
    // wide enough for offset + header + 24-bit data size + trailing size
    localparam int AGG_SUM_W   = 27;

    typedef struct packed {
        logic        op;
        logic [7:0]  packet_type;
        logic [23:0] body_length;
        logic [31:0] pkt_timestamp;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0]                   count;
        logic [MAX_RESULTS-1:0][7:0]  bytes;
        logic                         status_only;
        logic [1:0]                   status;
        logic                         done;
        logic [31:0]                  ts;
    } burst_t;

endpackage

@@ hw/rtl/mpfv_in_reg.sv @@
// ----------------------------------------------------------------------------
// mpfv_in_reg
// Input register stage: holds one accepted request until the core takes it.
// ----------------------------------------------------------------------------
module mpfv_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mpfv_pkg::in_item_t s_item,
    input  logic              advance,
    output logic              item_valid,
    output mpfv_pkg::in_item_t item
);
    import mpfv_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

@@ hw/rtl/mpfv_core.sv @@
// ----------------------------------------------------------------------------
// mpfv_core
// Packet state and per-request framing logic; builds the result burst.
// ----------------------------------------------------------------------------
module mpfv_core #(
    parameter int LENGTH_BITS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  mpfv_pkg::in_item_t item,
    output mpfv_pkg::burst_t   burst
);
    import mpfv_pkg::*;

    localparam int LW = LENGTH_BITS;
    localparam int SW = AGG_SUM_W;

    logic          in_packet_reg, in_packet_next;
    logic [1:0]    kind_reg, kind_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic [LW-1:0] total_reg, total_next;
    logic [LW-1:0] start_reg, start_next;
    logic [23:0]   size_reg, size_next;
    logic [23:0]   gather_reg, gather_next;
    logic [31:0]   running_ts_reg, running_ts_next;
    logic          corrupt_reg, corrupt_next;

    logic [LW-1:0] len_v;
    logic [23:0]   len24;
    logic [LW:0]   pos_inc;
    logic          last_v;
    logic [LW-1:0] rel_v;
    logic [SW-1:0] start_w, total_w, rel_w, size_w, d_w, k_w, nx_w;
    logic [31:0]   d32, tag_size32;
    logic [31:0]   ts_v;
    logic [7:0]    db;
    logic [7:0]    size_byte;
    logic          is_drop;

    assign len_v      = item.body_length[LW-1:0];
    assign len24      = 24'(len_v);
    assign ts_v       = item.pkt_timestamp;
    assign db         = item.data_byte;
    assign pos_inc    = {1'b0, pos_reg} + {{LW{1'b0}}, 1'b1};
    assign last_v     = pos_inc >= {1'b0, total_reg};
    assign rel_v      = pos_reg - start_reg;
    assign start_w    = SW'(start_reg);
    assign total_w    = SW'(total_reg);
    assign rel_w      = SW'(rel_v);
    assign size_w     = SW'(size_reg);
    assign d_w        = size_w + SW'(TAG_HDR_LEN);
    assign k_w        = rel_w - d_w;
    assign nx_w       = start_w + d_w + SW'(4);
    assign d32        = 32'(d_w);
    assign tag_size32 = 32'(total_reg) + 32'(TAG_HDR_LEN);
    assign is_drop    = (item.packet_type == TYPE_VIDEO && len_v <= LW'(5))
                     || (item.packet_type == TYPE_AUDIO && len_v <= LW'(1));

    // pick the byte of the rewritten sub-tag size, most significant first
    always_comb begin
        unique case (k_w[1:0])
            2'd0:    size_byte = d32[31:24];
            2'd1:    size_byte = d32[23:16];
            2'd2:    size_byte = d32[15:8];
            default: size_byte = d32[7:0];
        endcase
    end

    always_comb begin
        in_packet_next  = in_packet_reg;
        kind_next       = kind_reg;
        pos_next        = pos_reg;
        total_next      = total_reg;
        start_next      = start_reg;
        size_next       = size_reg;
        gather_next     = gather_reg;
        running_ts_next = running_ts_reg;
        corrupt_next    = corrupt_reg;
        burst           = '0;

        if (item.op == OP_START) begin
            in_packet_next = 1'b0;
            corrupt_next   = 1'b0;
            pos_next       = '0;
            total_next     = len_v;
            start_next     = '0;
            size_next      = '0;
            gather_next    = '0;
            if (is_drop) begin
                kind_next         = KIND_DROP;
                in_packet_next    = len_v != '0;
                burst.count       = 4'd1;
                burst.status_only = 1'b1;
                burst.status      = ST_SMALL;
                burst.done        = 1'b1;
            end else if (item.packet_type == TYPE_AUDIO || item.packet_type == TYPE_VIDEO
                         || item.packet_type == TYPE_METADATA) begin
                kind_next       = KIND_TAG;
                running_ts_next = ts_v;
                burst.bytes[0]  = item.packet_type;
                burst.bytes[1]  = len24[23:16];
                burst.bytes[2]  = len24[15:8];
                burst.bytes[3]  = len24[7:0];
                burst.bytes[4]  = ts_v[23:16];
                burst.bytes[5]  = ts_v[15:8];
                burst.bytes[6]  = ts_v[7:0];
                burst.bytes[7]  = ts_v[31:24];
                if (len_v == '0) begin
                    // empty body: previous-tag size is the bare header
                    burst.bytes[14] = 8'(TAG_HDR_LEN);
                    burst.count     = 4'(MAX_RESULTS);
                    burst.done      = 1'b1;
                end else begin
                    burst.count    = 4'(TAG_HDR_LEN);
                    in_packet_next = 1'b1;
                end
            end else if (item.packet_type == TYPE_AGGREGATE) begin
                kind_next = KIND_AGG;
                if (len_v == '0) begin
                    burst.count       = 4'd1;
                    burst.status_only = 1'b1;
                    burst.status      = ST_OK;
                    burst.done        = 1'b1;
                end else begin
                    in_packet_next = 1'b1;
                end
            end else begin
                kind_next = KIND_PASS;
                if (len_v == '0) begin
                    burst.count = 4'd4;
                    burst.done  = 1'b1;
                end else begin
                    in_packet_next = 1'b1;
                end
            end
        end else if (in_packet_reg) begin
            pos_next = pos_inc[LW-1:0];
            unique case (kind_reg)
                KIND_TAG: begin
                    burst.bytes[0] = db;
                    burst.bytes[1] = tag_size32[31:24];
                    burst.bytes[2] = tag_size32[23:16];
                    burst.bytes[3] = tag_size32[15:8];
                    burst.bytes[4] = tag_size32[7:0];
                    burst.count    = last_v ? 4'd5 : 4'd1;
                end
                KIND_PASS: begin
                    burst.bytes[0] = db;
                    burst.count    = last_v ? 4'd5 : 4'd1;
                end
                KIND_AGG: begin
                    priority if (corrupt_reg) begin
                        burst.count = 4'd0;
                    end else if (!(start_w + SW'(TAG_HDR_LEN) < total_w)
                                 || pos_reg < start_reg) begin
                        // outside the scanned part: pass through
                        burst.bytes[0] = db;
                        burst.count    = 4'd1;
                    end else if (rel_w >= SW'(1) && rel_w <= SW'(3)) begin
                        size_next      = (rel_w == SW'(1)) ? 24'(db) : {size_reg[15:0], db};
                        burst.bytes[0] = db;
                        burst.count    = 4'd1;
                    end else if (rel_w >= SW'(4) && rel_w <= SW'(6)) begin
                        gather_next    = (rel_w == SW'(4)) ? 24'(db)
                                                           : {gather_reg[15:0], db};
                        burst.bytes[0] = db;
                        burst.count    = 4'd1;
                    end else if (rel_w == SW'(7)) begin
                        running_ts_next = {db, gather_reg};
                        if (start_w + d_w > total_w) begin
                            corrupt_next      = 1'b1;
                            burst.count       = 4'd1;
                            burst.status_only = 1'b1;
                            burst.status      = ST_CORRUPT;
                            burst.done        = 1'b1;
                        end else begin
                            burst.bytes[0] = db;
                            burst.count    = 4'd1;
                        end
                    end else if (rel_w < SW'(TAG_HDR_LEN)) begin
                        burst.bytes[0] = db;
                        burst.count    = 4'd1;
                    end else if (nx_w <= total_w) begin
                        // trailing size fits: rewrite it
                        burst.bytes[0] = (rel_w < d_w) ? db : size_byte;
                        burst.count    = 4'd1;
                        if (rel_w >= d_w && k_w >= SW'(3)) begin
                            start_next = (nx_w > total_w) ? total_reg : nx_w[LW-1:0];
                        end
                    end else if (rel_w < d_w) begin
                        // size missing: append it after the last data byte
                        burst.bytes[0] = db;
                        burst.bytes[1] = d32[31:24];
                        burst.bytes[2] = d32[23:16];
                        burst.bytes[3] = d32[15:8];
                        burst.bytes[4] = d32[7:0];
                        burst.count    = last_v ? 4'd5 : 4'd1;
                    end else begin
                        // drop stray bytes, append size on the last one
                        burst.bytes[0] = d32[31:24];
                        burst.bytes[1] = d32[23:16];
                        burst.bytes[2] = d32[15:8];
                        burst.bytes[3] = d32[7:0];
                        burst.count    = last_v ? 4'd4 : 4'd0;
                    end
                end
                default: begin
                    burst.count = 4'd0;
                end
            endcase
            if (last_v) begin
                in_packet_next = 1'b0;
                if (burst.count != 4'd0) begin
                    burst.done = 1'b1;
                end
            end
        end
        burst.ts = running_ts_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_packet_reg  <= 1'b0;
            kind_reg       <= KIND_TAG;
            pos_reg        <= '0;
            total_reg      <= '0;
            start_reg      <= '0;
            size_reg       <= '0;
            gather_reg     <= '0;
            running_ts_reg <= '0;
            corrupt_reg    <= 1'b0;
        end else if (advance) begin
            in_packet_reg  <= in_packet_next;
            kind_reg       <= kind_next;
            pos_reg        <= pos_next;
            total_reg      <= total_next;
            start_reg      <= start_next;
            size_reg       <= size_next;
            gather_reg     <= gather_next;
            running_ts_reg <= running_ts_next;
            corrupt_reg    <= corrupt_next;
        end
    end

endmodule

@@ hw/rtl/mpfv_emit.sv @@
// ----------------------------------------------------------------------------
// mpfv_emit
// Result register: holds one burst and shifts it out one result per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module mpfv_emit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  mpfv_pkg::burst_t burst,
    output logic             can_load,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_byte_valid,
    output logic             m_last_of_run,
    output logic             m_packet_done,
    output logic [1:0]       m_status,
    output logic [31:0]      m_ts_out
);
    import mpfv_pkg::*;

    logic [MAX_RESULTS-1:0][7:0] bytes_reg;
    logic [3:0]                  rem_reg;
    logic                        status_only_reg;
    logic [1:0]                  status_reg;
    logic                        done_reg;
    logic [31:0]                 ts_reg;
    logic                        take;
    logic                        load;

    assign take     = m_valid && m_ready;
    assign can_load = (rem_reg == 4'd0) || (take && rem_reg == 4'd1);
    assign load     = advance && burst.count != 4'd0;

    assign m_valid       = rem_reg != 4'd0;
    assign m_out_byte    = bytes_reg[0];
    assign m_byte_valid  = !status_only_reg;
    assign m_status      = status_reg;
    assign m_last_of_run = rem_reg == 4'd1;
    assign m_packet_done = (rem_reg == 4'd1) && done_reg;
    assign m_ts_out      = ts_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 4'd0;
        end else if (load) begin
            rem_reg <= burst.count;
        end else if (take) begin
            rem_reg <= rem_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg       <= burst.bytes;
            status_only_reg <= burst.status_only;
            status_reg      <= burst.status;
            done_reg        <= burst.done;
            ts_reg          <= burst.ts;
        end else if (take) begin
            // advance to the next result
            bytes_reg <= {8'h00, bytes_reg[MAX_RESULTS-1:1]};
        end
    end

endmodule

@@ hw/rtl/media_packet_to_flv_tag_framer.sv @@
// A request is registered in the input stage, then its burst is loaded into
// the result register, which presents its first result; a busy result register
// stalls the load. Throughput: one result per cycle while m_ready is high; a
// one-result body byte request is then taken every cycle, one with more results
// holds the input until its results drain (at most 15, a tag header with empty
// body). Reset: aresetn, synchronous, active low, clears packet state and both valid stages.
// ----------------------------------------------------------------------------
// media_packet_to_flv_tag_framer
// Frames streamed media packets as FLV tags with header and trailing size.
// ----------------------------------------------------------------------------
module media_packet_to_flv_tag_framer #(
    parameter int LENGTH_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_packet_type,
    input  logic [23:0] s_body_length,
    input  logic [31:0] s_pkt_timestamp,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic        m_last_of_run,
    output logic        m_packet_done,
    output logic [1:0]  m_status,
    output logic [31:0] m_ts_out
);
    import mpfv_pkg::*;

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     can_load;
    logic     advance;
    burst_t   burst;

    assign s_item.op            = s_op;
    assign s_item.packet_type   = s_packet_type;
    assign s_item.body_length   = s_body_length;
    assign s_item.pkt_timestamp = s_pkt_timestamp;
    assign s_item.data_byte     = s_data_byte;

    assign advance = item_valid && can_load;

    mpfv_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mpfv_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .burst   (burst)
    );

    mpfv_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .burst         (burst),
        .can_load      (can_load),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_byte_valid  (m_byte_valid),
        .m_last_of_run (m_last_of_run),
        .m_packet_done (m_packet_done),
        .m_status      (m_status),
        .m_ts_out      (m_ts_out)
    );

endmodule

@@ hw/rtl/mpfv_checker.sv @@
// ----------------------------------------------------------------------------
// mpfv_checker
// Port-level checks of the framer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "media_packet_to_flv_tag_framer_assert.svh"

module mpfv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_byte_valid,
    input logic        m_last_of_run,
    input logic        m_packet_done,
    input logic [1:0]  m_status
);
    import mpfv_pkg::*;

    `MPFV_ASSERT_HOLD(a_out_hold, aclk, aresetn, m_valid, m_ready, m_out_byte)
    // status-only results stand alone in their run
    `MPFV_ASSERT_IMPLY(a_status_alone, aclk, aresetn, m_valid && !m_byte_valid, m_last_of_run)
    `MPFV_ASSERT_IMPLY(a_done_last, aclk, aresetn, m_valid && m_packet_done, m_last_of_run)
    `MPFV_ASSERT_IMPLY(a_status_nobyte, aclk, aresetn, m_valid && m_status != ST_OK, !m_byte_valid)

endmodule

bind media_packet_to_flv_tag_framer mpfv_checker u_mpfv_checker (.*);

@@ verif/mpfv_stream_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mpfv_stream_checker
// Watches both channels of the FLV tag framer, predicts the byte stream and
// status results of every accepted request, and compares each accepted result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module mpfv_stream_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_packet_type,
    input  logic [23:0] s_body_length,
    input  logic [31:0] s_pkt_timestamp,
    input  logic [7:0]  s_data_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_byte_valid,
    input  logic        m_last_of_run,
    input  logic        m_packet_done,
    input  logic [1:0]  m_status,
    input  logic [31:0] m_ts_out,
    output int unsigned mismatch_count,
    output int unsigned pending_results,
    output int unsigned results_checked,
    output int unsigned drops_seen,
    output int unsigned corrupts_seen
);
    import mpfv_pkg::*;

    typedef struct packed {
        logic [7:0]  data;
        logic        byte_ok;
        logic        last;
        logic        done;
        logic [1:0]  status;
        logic [31:0] ts;
    } flv_result_t;

    flv_result_t flv_expected[$];
    flv_result_t run_results[$];
    bit          run_done;

    // framer state as the predictor sees it
    bit          open_packet;
    logic [1:0]  pkt_kind;
    logic [23:0] pkt_pos;
    logic [23:0] pkt_total;
    logic [23:0] tag_base;
    logic [23:0] tag_data_size;
    logic [31:0] tag_ts;
    logic [31:0] stream_ts;
    bit          agg_corrupt;

    function automatic void clear_framer();
        open_packet   = 1'b0;
        pkt_kind      = KIND_TAG;
        pkt_pos       = '0;
        pkt_total     = '0;
        tag_base      = '0;
        tag_data_size = '0;
        tag_ts        = '0;
        stream_ts     = '0;
        agg_corrupt   = 1'b0;
    endfunction

    function automatic void emit(logic [7:0] data, logic byte_ok, logic [1:0] status);
        flv_result_t r;
        r         = '0;
        r.data    = data;
        r.byte_ok = byte_ok;
        r.status  = status;
        run_results.push_back(r);
    endfunction

    function automatic void emit_size(logic [31:0] v);
        emit(v[31:24], 1'b1, ST_OK);
        emit(v[23:16], 1'b1, ST_OK);
        emit(v[15:8], 1'b1, ST_OK);
        emit(v[7:0], 1'b1, ST_OK);
    endfunction

    task automatic start_packet(logic [7:0] ptype, logic [23:0] plen, logic [31:0] pts);
        open_packet   = 1'b0;
        agg_corrupt   = 1'b0;
        pkt_pos       = '0;
        pkt_total     = plen;
        tag_base      = '0;
        tag_data_size = '0;
        tag_ts        = '0;
        if ((ptype == TYPE_VIDEO && plen <= 5) || (ptype == TYPE_AUDIO && plen <= 1)) begin
            // too small to frame: report and swallow the body
            pkt_kind    = KIND_DROP;
            open_packet = (plen != 0);
            run_done    = 1'b1;
            emit(8'h00, 1'b0, ST_SMALL);
        end else if (ptype == TYPE_AUDIO || ptype == TYPE_VIDEO || ptype == TYPE_METADATA) begin
            pkt_kind  = KIND_TAG;
            stream_ts = pts;
            emit(ptype, 1'b1, ST_OK);
            emit(plen[23:16], 1'b1, ST_OK);
            emit(plen[15:8], 1'b1, ST_OK);
            emit(plen[7:0], 1'b1, ST_OK);
            emit(pts[23:16], 1'b1, ST_OK);
            emit(pts[15:8], 1'b1, ST_OK);
            emit(pts[7:0], 1'b1, ST_OK);
            emit(pts[31:24], 1'b1, ST_OK);
            repeat (3) emit(8'h00, 1'b1, ST_OK);
            if (plen == 0) begin
                emit_size(TAG_HDR_LEN);
                run_done = 1'b1;
            end else begin
                open_packet = 1'b1;
            end
        end else if (ptype == TYPE_AGGREGATE) begin
            pkt_kind = KIND_AGG;
            if (plen == 0) begin
                run_done = 1'b1;
                emit(8'h00, 1'b0, ST_OK);
            end else begin
                open_packet = 1'b1;
            end
        end else begin
            pkt_kind = KIND_PASS;
            if (plen == 0) begin
                run_done = 1'b1;
                emit_size(32'd0);
            end else begin
                open_packet = 1'b1;
            end
        end
    endtask

    task automatic agg_byte(int unsigned i, logic [7:0] db, bit last);
        int unsigned base;
        int unsigned rel;
        int unsigned span;
        int unsigned k;
        int unsigned nx;
        base = tag_base;
        if (agg_corrupt) begin
            // rest of a corrupt aggregate is swallowed
        end else if (!(base + TAG_HDR_LEN < pkt_total) || i < base) begin
            emit(db, 1'b1, ST_OK);
        end else begin
            rel = i - base;
            if (rel >= 1 && rel <= 3) begin
                tag_data_size = (rel == 1) ? {16'd0, db} : {tag_data_size[15:0], db};
                emit(db, 1'b1, ST_OK);
            end else if (rel >= 4 && rel <= 6) begin
                tag_ts = (rel == 4) ? {24'd0, db} : {8'd0, tag_ts[15:0], db};
                emit(db, 1'b1, ST_OK);
            end else if (rel == 7) begin
                tag_ts    = {db, tag_ts[23:0]};
                stream_ts = tag_ts;
                if (base + TAG_HDR_LEN + tag_data_size > pkt_total) begin
                    agg_corrupt = 1'b1;
                    run_done    = 1'b1;
                    emit(8'h00, 1'b0, ST_CORRUPT);
                end else begin
                    emit(db, 1'b1, ST_OK);
                end
            end else if (rel < TAG_HDR_LEN) begin
                emit(db, 1'b1, ST_OK);
            end else begin
                span = TAG_HDR_LEN + tag_data_size;
                if (base + span + 4 <= pkt_total) begin
                    if (rel < span) begin
                        emit(db, 1'b1, ST_OK);
                    end else begin
                        // rewrite the trailing size, then advance to the next sub-tag
                        k = rel - span;
                        emit(8'(span >> (8 * (3 - (k & 3)))), 1'b1, ST_OK);
                        if (k >= 3) begin
                            nx = base + span + 4;
                            tag_base = (nx > pkt_total) ? pkt_total : 24'(nx);
                        end
                    end
                end else begin
                    // final size missing: drop stray bytes, append the size at the end
                    if (rel < span) emit(db, 1'b1, ST_OK);
                    if (last) emit_size(span);
                end
            end
        end
    endtask

    task automatic body_byte(logic [7:0] db);
        int unsigned i;
        bit          last;
        i       = pkt_pos;
        last    = (i + 1 >= pkt_total);
        pkt_pos = pkt_pos + 24'd1;
        case (pkt_kind)
            KIND_TAG: begin
                emit(db, 1'b1, ST_OK);
                if (last) emit_size(TAG_HDR_LEN + pkt_total);
            end
            KIND_PASS: begin
                emit(db, 1'b1, ST_OK);
                if (last) emit_size(32'd0);
            end
            KIND_AGG: begin
                agg_byte(i, db, last);
            end
            default: begin
            end
        endcase
        if (last) begin
            open_packet = 1'b0;
            if (run_results.size() > 0) run_done = 1'b1;
        end
    endtask

    task automatic frame_request(logic op, logic [7:0] ptype, logic [23:0] plen,
                                 logic [31:0] pts, logic [7:0] db);
        flv_result_t r;
        run_results.delete();
        run_done = 1'b0;
        if (op == OP_START) begin
            start_packet(ptype, plen, pts);
        end else if (open_packet) begin
            body_byte(db);
        end
        for (int k = 0; k < run_results.size(); k++) begin
            r    = run_results[k];
            r.ts = stream_ts;
            if (k == run_results.size() - 1) begin
                r.last = 1'b1;
                r.done = run_done;
            end
            flv_expected.push_back(r);
        end
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic check_result();
        flv_result_t want;
        if (flv_expected.size() == 0) begin
            report_mismatch("result with nothing expected", {24'd0, m_out_byte}, 32'd0);
        end else begin
            want = flv_expected.pop_front();
            results_checked++;
            if (want.status == ST_SMALL) drops_seen++;
            if (want.status == ST_CORRUPT) corrupts_seen++;
            if (m_out_byte !== want.data) report_mismatch("out_byte", m_out_byte, want.data);
            if (m_byte_valid !== want.byte_ok)
                report_mismatch("byte_valid", m_byte_valid, want.byte_ok);
            if (m_last_of_run !== want.last)
                report_mismatch("last_of_run", m_last_of_run, want.last);
            if (m_packet_done !== want.done)
                report_mismatch("packet_done", m_packet_done, want.done);
            if (m_status !== want.status) report_mismatch("status", m_status, want.status);
            if (m_ts_out !== want.ts) report_mismatch("ts_out", m_ts_out, want.ts);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_framer();
            flv_expected.delete();
        end else begin
            if (s_valid && s_ready) begin
                frame_request(s_op, s_packet_type, s_body_length, s_pkt_timestamp,
                              s_data_byte);
            end
            if (m_valid && m_ready) check_result();
        end
        pending_results <= flv_expected.size();
    end

endmodule

@@ verif/tb_media_packet_to_flv_tag_framer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_media_packet_to_flv_tag_framer
// Drives media packet requests into the FLV tag framer: a directed opening of
// edge cases, then random tagged, pass-through and aggregate packets with
// noise, under changing sender and receiver idling and one long receiver
// hold-off. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_media_packet_to_flv_tag_framer;
    import mpfv_pkg::*;

    localparam int RANDOM_ITEMS    = 350;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 24;
    localparam int WATCHDOG_LIMIT  = 3000;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic        s_op            = OP_START;
    logic [7:0]  s_packet_type   = '0;
    logic [23:0] s_body_length   = '0;
    logic [31:0] s_pkt_timestamp = '0;
    logic [7:0]  s_data_byte     = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_byte_valid;
    logic        m_last_of_run;
    logic        m_packet_done;
    logic [1:0]  m_status;
    logic [31:0] m_ts_out;

    int unsigned mismatch_count;
    int unsigned pending_results;
    int unsigned results_checked;
    int unsigned drops_seen;
    int unsigned corrupts_seen;

    int unsigned src_idle_pct  = 25;
    int unsigned sink_idle_pct = 81;
    int unsigned hold_asks     = 0;
    int unsigned packet_items  = 0;
    int unsigned requests_sent = 0;
    int unsigned quiet_cycles  = 0;
    logic [7:0]  pkt_body[$];

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    media_packet_to_flv_tag_framer DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_packet_type   (s_packet_type),
        .s_body_length   (s_body_length),
        .s_pkt_timestamp (s_pkt_timestamp),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_byte_valid    (m_byte_valid),
        .m_last_of_run   (m_last_of_run),
        .m_packet_done   (m_packet_done),
        .m_status        (m_status),
        .m_ts_out        (m_ts_out)
    );

    mpfv_stream_checker flv_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_packet_type   (s_packet_type),
        .s_body_length   (s_body_length),
        .s_pkt_timestamp (s_pkt_timestamp),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_byte_valid    (m_byte_valid),
        .m_last_of_run   (m_last_of_run),
        .m_packet_done   (m_packet_done),
        .m_status        (m_status),
        .m_ts_out        (m_ts_out),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .drops_seen      (drops_seen),
        .corrupts_seen   (corrupts_seen)
    );

    task automatic send_request(logic op, logic [7:0] ptype, logic [23:0] plen,
                                logic [31:0] pts, logic [7:0] db);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        // fields the op ignores still carry random values
        s_packet_type   <= (op == OP_START) ? ptype : 8'($urandom);
        s_body_length   <= (op == OP_START) ? plen : 24'($urandom);
        s_pkt_timestamp <= (op == OP_START) ? pts : 32'($urandom);
        s_data_byte     <= (op == OP_BYTE) ? db : 8'($urandom);
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    // start item, then nbytes body bytes taken from pkt_body, random past its end
    task automatic send_packet(logic [7:0] ptype, logic [23:0] plen, logic [31:0] pts,
                               int unsigned nbytes);
        send_request(OP_START, ptype, plen, pts, 8'h00);
        for (int unsigned k = 0; k < nbytes; k++) begin
            send_request(OP_BYTE, 8'h00, 24'd0, 32'd0,
                         (k < pkt_body.size()) ? pkt_body[k] : 8'($urandom));
        end
        packet_items += nbytes + 1;
    endtask

    function automatic void add_sub_tag(int unsigned data_len, logic [23:0] declared_len,
                                        int unsigned size_len);
        logic [31:0] sub_ts;
        logic [7:0]  sub_type;
        sub_ts = $urandom;
        case ($urandom_range(2))
            0:       sub_type = TYPE_AUDIO;
            1:       sub_type = TYPE_VIDEO;
            default: sub_type = TYPE_METADATA;
        endcase
        pkt_body.push_back(sub_type);
        pkt_body.push_back(declared_len[23:16]);
        pkt_body.push_back(declared_len[15:8]);
        pkt_body.push_back(declared_len[7:0]);
        pkt_body.push_back(sub_ts[23:16]);
        pkt_body.push_back(sub_ts[15:8]);
        pkt_body.push_back(sub_ts[7:0]);
        pkt_body.push_back(sub_ts[31:24]);
        repeat (3) pkt_body.push_back(8'h00);
        repeat (data_len) pkt_body.push_back(8'($urandom));
        // trailing size carries junk, the framer rewrites it
        repeat (size_len) pkt_body.push_back(8'($urandom));
    endfunction

    function automatic void build_aggregate();
        int unsigned tags;
        int unsigned data_len;
        pkt_body.delete();
        tags = $urandom_range(1, 3);
        for (int unsigned t = 1; t <= tags; t++) begin
            data_len = $urandom_range(0, 12);
            if (t < tags) begin
                add_sub_tag(data_len, 24'(data_len), 4);
            end else begin
                case ($urandom_range(3))
                    0: add_sub_tag(data_len, 24'(data_len), 4);
                    // final size missing, up to three stray bytes in its place
                    1: add_sub_tag(data_len, 24'(data_len), $urandom_range(0, 3));
                    // declared size runs past the end of the packet
                    2: add_sub_tag(data_len, $urandom_range(1) ?
                                   24'(data_len + $urandom_range(5, 40)) :
                                   (24'($urandom) | 24'h80_0000), 4);
                    default: begin
                        add_sub_tag(data_len, 24'(data_len), 4);
                        // tail too short to hold another sub-tag header
                        repeat ($urandom_range(1, 11)) pkt_body.push_back(8'($urandom));
                    end
                endcase
            end
        end
    endfunction

    initial begin : sink_side
        int unsigned holds_served;
        holds_served = 0;
        forever begin
            @(posedge aclk);
            if (holds_served != hold_asks) begin
                holds_served++;
                // hold off results so the framer backs up into its input
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned pick;
        int unsigned blen;
        int unsigned phase;
        logic [7:0]  ptype;
        phase = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // byte with no packet open
        send_request(OP_BYTE, 8'h00, 24'd0, 32'd0, 8'hFF);
        // metadata with empty body: longest burst, all-ones timestamp
        send_request(OP_START, TYPE_METADATA, 24'd0, 32'hFFFF_FFFF, 8'h00);
        send_request(OP_START, TYPE_AUDIO, 24'd0, 32'h0000_0001, 8'h00);
        // one-byte audio is dropped and its byte swallowed
        send_request(OP_START, TYPE_AUDIO, 24'd1, 32'h1234_5678, 8'h00);
        send_request(OP_BYTE, 8'h00, 24'd0, 32'd0, 8'h00);
        // five-byte video is dropped, then abandoned by the next start
        send_request(OP_START, TYPE_VIDEO, 24'd5, 32'h0F0F_0F0F, 8'h00);
        send_request(OP_BYTE, 8'h00, 24'd0, 32'd0, 8'hAA);
        send_request(OP_BYTE, 8'h00, 24'd0, 32'd0, 8'h55);
        send_request(OP_START, TYPE_VIDEO, 24'd0, 32'h8000_0000, 8'h00);
        send_request(OP_START, TYPE_AGGREGATE, 24'd0, 32'h7FFF_FFFF, 8'h00);
        send_request(OP_START, 8'hFF, 24'd0, 32'h00FF_FF00, 8'h00);
        // longest body length, abandoned after one byte
        send_request(OP_START, TYPE_VIDEO, 24'hFF_FFFF, 32'hFFFF_FFFF, 8'h00);
        send_request(OP_BYTE, 8'h00, 24'd0, 32'd0, 8'h80);
        // smallest video that is framed
        send_request(OP_START, TYPE_VIDEO, 24'd6, 32'hA5A5_5A5A, 8'h00);
        send_request(OP_BYTE, 8'h00, 24'd0, 32'd0, 8'h01);
        send_request(OP_START, TYPE_AUDIO, 24'd2, 32'd0, 8'h00);
        send_request(OP_BYTE, 8'h00, 24'd0, 32'd0, 8'h00);
        send_request(OP_BYTE, 8'h00, 24'd0, 32'd0, 8'hFF);
        send_request(OP_START, 8'h00, 24'd1, 32'hDEAD_BEEF, 8'h00);
        send_request(OP_BYTE, 8'h00, 24'd0, 32'd0, 8'hA5);
        send_request(OP_START, TYPE_METADATA, 24'd1, 32'h0000_0100, 8'h00);
        send_request(OP_BYTE, 8'h00, 24'd0, 32'd0, 8'h5A);
        // aggregate too short to scan passes its bytes through
        send_request(OP_START, TYPE_AGGREGATE, 24'd3, 32'h0102_0304, 8'h00);
        repeat (3) send_request(OP_BYTE, 8'h00, 24'd0, 32'd0, 8'($urandom));

        while (packet_items < RANDOM_ITEMS) begin
            if (phase == 0 && packet_items >= RANDOM_ITEMS / 3) begin
                phase         = 1;
                src_idle_pct  = 81;
                sink_idle_pct = 25;
            end else if (phase == 1 && packet_items >= 2 * RANDOM_ITEMS / 3) begin
                phase         = 2;
                src_idle_pct  = 0;
                sink_idle_pct = 0;
                hold_asks++;
            end
            pick = $urandom_range(99);
            pkt_body.delete();
            if (pick < 30) begin
                case ($urandom_range(2))
                    0:       ptype = TYPE_AUDIO;
                    1:       ptype = TYPE_VIDEO;
                    default: ptype = TYPE_METADATA;
                endcase
                blen = $urandom_range(0, 16);
                send_packet(ptype, 24'(blen), $urandom, blen);
            end else if (pick < 60) begin
                build_aggregate();
                send_packet(TYPE_AGGREGATE, 24'(pkt_body.size()), $urandom, pkt_body.size());
            end else if (pick < 70) begin
                do ptype = 8'($urandom);
                while (ptype == TYPE_AUDIO || ptype == TYPE_VIDEO ||
                       ptype == TYPE_METADATA || ptype == TYPE_AGGREGATE);
                blen = $urandom_range(0, 8);
                send_packet(ptype, 24'(blen), $urandom, blen);
            end else if (pick < 82) begin
                // arbitrary start, usually left unfinished
                send_packet(8'($urandom), 24'($urandom), $urandom, $urandom_range(0, 3));
            end else if (pick < 94) begin
                if ($urandom_range(1)) begin
                    // aggregate cut off before its end
                    build_aggregate();
                    send_packet(TYPE_AGGREGATE, 24'(pkt_body.size()), $urandom,
                                $urandom_range(0, pkt_body.size() - 1));
                end else begin
                    blen = $urandom_range(12, 30);
                    send_packet(TYPE_AGGREGATE, 24'(blen), $urandom, blen);
                end
            end else begin
                repeat ($urandom_range(1, 3)) send_request(OP_BYTE, 8'h00, 24'd0, 32'd0,
                                                           8'($urandom));
            end
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d requests, %0d of them in random packets; %0d results checked.",
                 requests_sent, packet_items, results_checked);
        $display("Dropped packets: %0d, corrupt aggregates: %0d, receiver hold-off: %0d cycles.",
                 drops_seen, corrupts_seen, HOLD_OFF_CYCLES);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
